FILE: sv/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg: shared types and constants of the sync/checksum frame deframer
// Widths, register reset values and frame status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package scfd_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned SeqW    = 16;
  localparam int unsigned StatusW = 3;

  // Register reset values
  localparam logic [DataW-1:0] ExpLenRst = 8'h00;
  localparam logic [DataW-1:0] Sync1Rst  = 8'hAA;
  localparam logic [DataW-1:0] Sync2Rst  = 8'h55;

  // Frame verdict codes
  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StNoSync   = 3'd1,
    StShortHdr = 3'd2,
    StLenBad   = 3'd3,
    StTrunc    = 3'd4,
    StSumBad   = 3'd5,
    StTrailBad = 3'd6
  } status_e;

  // One result as held in the output queue
  typedef struct packed {
    logic               kind;
    logic [DataW-1:0]   payload_byte;
    logic [DataW-1:0]   byte_index;
    logic [StatusW-1:0] status;
    logic [SeqW-1:0]    sequence_res;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/scfd_in_if.sv
// ----------------------------------------------------------------------------
// scfd_in_if: received byte channel
// Valid/ready channel carrying one buffer byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [scfd_pkg::DataW-1:0]  rx_byte;
  logic                        end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

FILE: sv/scfd_out_if.sv
// ----------------------------------------------------------------------------
// scfd_out_if: deframer result channel
// Valid/ready channel carrying payload byte results and buffer status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [scfd_pkg::DataW-1:0]    payload_byte;
  logic [scfd_pkg::DataW-1:0]    byte_index;
  logic [scfd_pkg::StatusW-1:0]  status;
  logic [scfd_pkg::SeqW-1:0]     sequence_res;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output status, output sequence_res, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input status, input sequence_res, output ready);
endinterface

`default_nettype wire

FILE: sv/sync_checksum_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// sync_checksum_frame_deframer_core: sync/length/sequence/checksum deframer
// Hunts a sync pair per receive buffer, checks the frame and streams payload.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i  : one received byte per request, end_of_buffer set on the last byte
//           of a receive buffer.
//   res_o : results. kind 0 is a payload byte (value and index in payload),
//           kind 1 is the buffer status with the last good sequence number.
//           The end-of-buffer byte always yields one status request; a buffer
//           ending on a payload byte yields the payload byte then the status.
//   APB   : expected_length at 0x0, sync_first at 0x4, sync_second at 0x8.
//           Write only while the block is idle.
// Each result is registered into the output queue when its byte is accepted.
// Throughput: one byte per cycle. Each byte does one pass through the phase
//   machine and a 16-bit adder; results go into a four-entry output queue.
//   rx_i.ready drops while the queue holds three or more results, so a
//   stalled receiver backs up into the byte channel without losing anything.
// Reset: frame state returns to hunting, last sequence clears, registers take
//   their defaults (length 0, syncs 0xAA and 0x55). The queue empties.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_checksum_frame_deframer_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  scfd_in_if.sink           rx_i,
  scfd_out_if.source        res_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned DataW = scfd_pkg::DataW;
  localparam int unsigned SeqW  = scfd_pkg::SeqW;

  // Phase codes
  localparam logic [3:0] PhHunt  = 4'd0;
  localparam logic [3:0] PhLen   = 4'd1;
  localparam logic [3:0] PhSeqLo = 4'd2;
  localparam logic [3:0] PhSeqHi = 4'd3;
  localparam logic [3:0] PhPay   = 4'd4;
  localparam logic [3:0] PhSumLo = 4'd5;
  localparam logic [3:0] PhSumHi = 4'd6;
  localparam logic [3:0] PhTr1   = 4'd7;
  localparam logic [3:0] PhTr2   = 4'd8;
  localparam logic [3:0] PhDone  = 4'd9;

  // Register indexes
  localparam logic [1:0] RegExpLen = 2'd0;
  localparam logic [1:0] RegSync1  = 2'd1;
  localparam logic [1:0] RegSync2  = 2'd2;

  localparam logic [2:0] MinBufLen = 3'd7;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DataW-1:0] exp_len_q, sync1_q, sync2_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= scfd_pkg::ExpLenRst;
      sync1_q   <= scfd_pkg::Sync1Rst;
      sync2_q   <= scfd_pkg::Sync2Rst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegExpLen: exp_len_q <= pwdata[DataW-1:0];
        RegSync1:  sync1_q   <= pwdata[DataW-1:0];
        RegSync2:  sync2_q   <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      RegExpLen: prdata = {24'd0, exp_len_q};
      RegSync1:  prdata = {24'd0, sync1_q};
      RegSync2:  prdata = {24'd0, sync2_q};
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  logic [3:0]        phase_q, phase_d;
  logic              prev_s1_q, prev_s1_d;
  logic [DataW-1:0]  pay_cnt_q, pay_cnt_d;
  logic [SeqW-1:0]   sum_q, sum_d;
  logic [SeqW-1:0]   rx_sum_q, rx_sum_d;
  logic [SeqW-1:0]   frame_seq_q, frame_seq_d;
  scfd_pkg::status_e pend_q, pend_d;
  logic [SeqW-1:0]   last_seq_q, last_seq_d;
  logic [2:0]        tally_q, tally_d;

  logic              accept;
  logic              short_hdr;
  logic              pay_vld;
  scfd_pkg::status_e code;
  scfd_pkg::res_t    pay_res, st_res;
  logic [DataW-1:0]  b;
  logic [SeqW-1:0]   sum_add;

  assign accept  = rx_i.valid && rx_i.ready;
  assign b       = rx_i.rx_byte;
  assign sum_add = sum_q + {8'd0, b};

  // One byte through the phase machine, then the end-of-buffer verdict
  always_comb begin
    phase_d     = phase_q;
    prev_s1_d   = prev_s1_q;
    pay_cnt_d   = pay_cnt_q;
    sum_d       = sum_q;
    rx_sum_d    = rx_sum_q;
    frame_seq_d = frame_seq_q;
    pend_d      = pend_q;
    last_seq_d  = last_seq_q;
    tally_d     = (tally_q < MinBufLen) ? tally_q + 3'd1 : tally_q;
    short_hdr   = 1'b0;
    pay_vld     = 1'b0;
    code        = scfd_pkg::StOk;

    unique case (phase_q)
      PhHunt: begin
        if (prev_s1_q && b == sync2_q) begin
          phase_d   = PhLen;
          sum_d     = {8'd0, sync1_q} + {8'd0, sync2_q};
          prev_s1_d = 1'b0;
        end else begin
          prev_s1_d = (b == sync1_q);
        end
      end
      PhLen: begin
        sum_d   = sum_add;
        pend_d  = (b != exp_len_q) ? scfd_pkg::StLenBad : scfd_pkg::StOk;
        phase_d = PhSeqLo;
      end
      PhSeqLo: begin
        frame_seq_d = {8'd0, b};
        sum_d       = sum_add;
        phase_d     = PhSeqHi;
      end
      PhSeqHi: begin
        frame_seq_d = {b, frame_seq_q[7:0]};
        sum_d       = sum_add;
        short_hdr   = 1'b1;
        pay_cnt_d   = '0;
        if (pend_q != scfd_pkg::StOk) begin
          phase_d = PhDone;
        end else if (exp_len_q == '0) begin
          phase_d = PhSumLo;
        end else begin
          phase_d = PhPay;
        end
      end
      PhPay: begin
        pay_vld   = 1'b1;
        sum_d     = sum_add;
        pay_cnt_d = pay_cnt_q + 8'd1;
        if (pay_cnt_d >= exp_len_q) phase_d = PhSumLo;
      end
      PhSumLo: begin
        rx_sum_d = {8'd0, b};
        phase_d  = PhSumHi;
      end
      PhSumHi: begin
        rx_sum_d = {b, rx_sum_q[7:0]};
        phase_d  = PhTr1;
      end
      PhTr1: begin
        pend_d  = (b != sync2_q) ? scfd_pkg::StTrailBad : scfd_pkg::StOk;
        phase_d = PhTr2;
      end
      PhTr2: begin
        if (b != sync1_q) pend_d = scfd_pkg::StTrailBad;
        if (rx_sum_q != sum_q) pend_d = scfd_pkg::StSumBad;
        phase_d = PhDone;
      end
      default: phase_d = PhDone;
    endcase

    // Verdict on the last byte of the buffer, then back to hunting
    if (rx_i.end_of_buffer) begin
      priority if (tally_d < MinBufLen || phase_d == PhHunt) begin
        code = scfd_pkg::StNoSync;
      end else if (short_hdr || phase_d == PhLen || phase_d == PhSeqLo ||
                   phase_d == PhSeqHi) begin
        code = scfd_pkg::StShortHdr;
      end else if (phase_d == PhDone) begin
        code = pend_d;
      end else begin
        code = scfd_pkg::StTrunc;
      end
      if (code == scfd_pkg::StOk) last_seq_d = frame_seq_d;
      phase_d     = PhHunt;
      prev_s1_d   = 1'b0;
      pay_cnt_d   = '0;
      sum_d       = '0;
      rx_sum_d    = '0;
      frame_seq_d = '0;
      pend_d      = scfd_pkg::StOk;
      tally_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      prev_s1_q   <= 1'b0;
      pay_cnt_q   <= '0;
      sum_q       <= '0;
      rx_sum_q    <= '0;
      frame_seq_q <= '0;
      pend_q      <= scfd_pkg::StOk;
      last_seq_q  <= '0;
      tally_q     <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      prev_s1_q   <= prev_s1_d;
      pay_cnt_q   <= pay_cnt_d;
      sum_q       <= sum_d;
      rx_sum_q    <= rx_sum_d;
      frame_seq_q <= frame_seq_d;
      pend_q      <= pend_d;
      last_seq_q  <= last_seq_d;
      tally_q     <= tally_d;
    end
  end

  // Results built from this byte
  assign pay_res = '{kind: 1'b0, payload_byte: b, byte_index: pay_cnt_q,
                     status: scfd_pkg::StOk, sequence_res: '0};
  assign st_res  = '{kind: 1'b1, payload_byte: '0, byte_index: '0,
                     status: code, sequence_res: last_seq_d};

  // --------------------------------------------------------------------------
  // Output queue: up to two pushes per byte, one pop per cycle
  // --------------------------------------------------------------------------
  scfd_pkg::res_t q_mem [4];
  logic [1:0]     wr_ptr_q, rd_ptr_q, st_ptr;
  logic [2:0]     cnt_q;
  logic [1:0]     push_n;
  logic           pop;

  assign rx_i.ready = (cnt_q <= 3'd2);
  assign pop        = res_o.valid && res_o.ready;
  assign push_n     = accept ? ({1'b0, pay_vld} + {1'b0, rx_i.end_of_buffer}) : 2'd0;
  assign st_ptr     = wr_ptr_q + {1'b0, pay_vld};

  always_ff @(posedge clk_i) begin
    if (accept && pay_vld) q_mem[wr_ptr_q] <= pay_res;
    if (accept && rx_i.end_of_buffer) q_mem[st_ptr] <= st_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_n} - {2'd0, pop};
    end
  end

  assign res_o.valid        = (cnt_q != 3'd0);
  assign res_o.kind         = q_mem[rd_ptr_q].kind;
  assign res_o.payload_byte = q_mem[rd_ptr_q].payload_byte;
  assign res_o.byte_index   = q_mem[rd_ptr_q].byte_index;
  assign res_o.status       = q_mem[rd_ptr_q].status;
  assign res_o.sequence_res = q_mem[rd_ptr_q].sequence_res;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("output queue overflow");

  a_eob_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx_i.end_of_buffer |=> phase_q == PhHunt && tally_q == 3'd0)
    else $error("frame state not cleared after end of buffer");

  a_eob_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx_i.end_of_buffer |=> cnt_q != 3'd0)
    else $error("status result missing after end of buffer");

  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHunt |-> pay_cnt_q == '0 && pend_q == scfd_pkg::StOk)
    else $error("stale frame state while hunting");

endmodule

`default_nettype wire

FILE: test/sync_checksum_frame_deframer_core_tb.sv
// ----------------------------------------------------------------------------
// sync_checksum_frame_deframer_core_tb: self-checking bench for the deframer
// Drives receive buffers (good frames, damaged frames, truncations and noise)
// under several idle/stall mixes and register settings. Each accepted byte runs
// through an in-bench deframer model. Every result is checked field by field
// against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_checksum_frame_deframer_core_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 4;

  // Register byte addresses
  localparam logic [3:0] AddrExpLen = 4'h0;
  localparam logic [3:0] AddrSync1  = 4'h4;
  localparam logic [3:0] AddrSync2  = 4'h8;

  typedef enum logic [3:0] {
    PhHunt, PhLen, PhSeqLo, PhSeqHi, PhPay, PhCrcLo, PhCrcHi, PhTr1, PhTr2, PhDone
  } dfr_phase_e;

  typedef enum int {
    FaultNone, FaultSum, FaultTrailFirst, FaultTrailLast, FaultSumTrail
  } frame_fault_e;

  logic clk = 1'b0;
  logic rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  scfd_in_if  rx_bus ();
  scfd_out_if res_bus ();

  sync_checksum_frame_deframer_core uut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .rx_i    (rx_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies
  logic [7:0] cfg_exp_len, cfg_sync1, cfg_sync2;

  // Deframer model state
  dfr_phase_e          dfr_phase;
  logic                after_sync1;
  logic [7:0]          pay_count;
  logic [15:0]         run_sum, rx_sum, frame_seq, good_seq;
  scfd_pkg::status_e   verdict_err;
  logic [2:0]          buf_tally;

  scfd_pkg::res_t frame_results_q[$];
  logic [7:0]  buf_q[$];
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function void reset_frame_state();
    dfr_phase   = PhHunt;
    after_sync1 = 1'b0;
    pay_count   = '0;
    run_sum     = '0;
    rx_sum      = '0;
    frame_seq   = '0;
    verdict_err = scfd_pkg::StOk;
    buf_tally   = '0;
  endfunction

  // Advance the model by one byte, queue the results it produces
  function void deframe_byte(input logic [7:0] b, input logic eob);
    scfd_pkg::res_t    r;
    logic              short_hdr;
    scfd_pkg::status_e code;
    short_hdr = 1'b0;
    if (buf_tally < 3'd7) buf_tally++;
    case (dfr_phase)
      PhHunt: begin
        if (after_sync1 && b == cfg_sync2) begin
          dfr_phase   = PhLen;
          run_sum     = {8'h00, cfg_sync1} + {8'h00, cfg_sync2};
          after_sync1 = 1'b0;
        end else begin
          after_sync1 = (b == cfg_sync1);
        end
      end
      PhLen: begin
        run_sum     = run_sum + {8'h00, b};
        verdict_err = (b != cfg_exp_len) ? scfd_pkg::StLenBad : scfd_pkg::StOk;
        dfr_phase   = PhSeqLo;
      end
      PhSeqLo: begin
        frame_seq = {8'h00, b};
        run_sum   = run_sum + {8'h00, b};
        dfr_phase = PhSeqHi;
      end
      PhSeqHi: begin
        frame_seq[15:8] = b;
        run_sum   = run_sum + {8'h00, b};
        short_hdr = 1'b1;
        pay_count = '0;
        if (verdict_err != scfd_pkg::StOk) dfr_phase = PhDone;
        else if (cfg_exp_len == 8'd0) dfr_phase = PhCrcLo;
        else dfr_phase = PhPay;
      end
      PhPay: begin
        r = '0;
        r.payload_byte = b;
        r.byte_index   = pay_count;
        frame_results_q.push_back(r);
        run_sum   = run_sum + {8'h00, b};
        pay_count = pay_count + 8'd1;
        if (pay_count >= cfg_exp_len) dfr_phase = PhCrcLo;
      end
      PhCrcLo: begin
        rx_sum    = {8'h00, b};
        dfr_phase = PhCrcHi;
      end
      PhCrcHi: begin
        rx_sum[15:8] = b;
        dfr_phase    = PhTr1;
      end
      PhTr1: begin
        verdict_err = (b != cfg_sync2) ? scfd_pkg::StTrailBad : scfd_pkg::StOk;
        dfr_phase   = PhTr2;
      end
      PhTr2: begin
        if (b != cfg_sync1) verdict_err = scfd_pkg::StTrailBad;
        if (rx_sum != run_sum) verdict_err = scfd_pkg::StSumBad;
        dfr_phase = PhDone;
      end
      default: dfr_phase = PhDone;
    endcase

    // Buffer verdict
    if (eob) begin
      if (buf_tally < 3'd7 || dfr_phase == PhHunt) code = scfd_pkg::StNoSync;
      else if (short_hdr || dfr_phase == PhLen || dfr_phase == PhSeqLo ||
               dfr_phase == PhSeqHi) code = scfd_pkg::StShortHdr;
      else if (dfr_phase == PhDone) code = verdict_err;
      else code = scfd_pkg::StTrunc;
      if (code == scfd_pkg::StOk) good_seq = frame_seq;
      r = '0;
      r.kind         = 1'b1;
      r.status       = code;
      r.sequence_res = good_seq;
      frame_results_q.push_back(r);
      reset_frame_state();
    end
  endfunction

  // Receiver side: random stalls
  always @(negedge clk) begin
    res_bus.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_checker
    scfd_pkg::res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (frame_results_q.size() == 0) begin
        $error("result with nothing expected: kind %0d status %0d",
               res_bus.kind, res_bus.status);
        errors++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("kind", want.kind, res_bus.kind);
        check_field("payload_byte", want.payload_byte, res_bus.payload_byte);
        check_field("byte_index", want.byte_index, res_bus.byte_index);
        check_field("status", want.status, res_bus.status);
        check_field("sequence_res", want.sequence_res, res_bus.sequence_res);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sync_checksum_frame_deframer_core_tb: FAIL");
      $finish;
    end
  end

  // Send one byte request; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_bus.valid = 1'b0;
      @(negedge clk);
    end
    rx_bus.valid         = 1'b1;
    rx_bus.rx_byte       = b;
    rx_bus.end_of_buffer = eob;
    do @(posedge clk); while (!rx_bus.ready);
    deframe_byte(b, eob);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Stop sending and let every predicted result come out
  task automatic wait_drain();
    rx_bus.valid = 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [7:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {24'h0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      AddrExpLen: cfg_exp_len = value;
      AddrSync1:  cfg_sync1   = value;
      AddrSync2:  cfg_sync2   = value;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] len, input logic [7:0] s1,
                                input logic [7:0] s2);
    wait_drain();
    write_reg(AddrExpLen, len);
    write_reg(AddrSync1, s1);
    write_reg(AddrSync2, s2);
  endtask

  task automatic push_noise(input int n);
    repeat (n) buf_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic drop_tail(input int n);
    repeat (n) void'(buf_q.pop_back());
  endtask

  // Build one frame in buf_q; fill < 0 means random payload
  task automatic build_frame(input int pre, input logic [7:0] len_byte, input int npay,
                             input logic [15:0] seq, input int fill,
                             input frame_fault_e fault);
    logic [15:0] sum;
    logic [7:0]  b;
    buf_q.delete();
    push_noise(pre);
    sum = {8'h00, cfg_sync1} + {8'h00, cfg_sync2} + {8'h00, len_byte} +
          {8'h00, seq[7:0]} + {8'h00, seq[15:8]};
    buf_q.push_back(cfg_sync1);
    buf_q.push_back(cfg_sync2);
    buf_q.push_back(len_byte);
    buf_q.push_back(seq[7:0]);
    buf_q.push_back(seq[15:8]);
    repeat (npay) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      buf_q.push_back(b);
      sum = sum + {8'h00, b};
    end
    if (fault == FaultSum || fault == FaultSumTrail) sum = sum ^ (16'h1 << $urandom_range(15));
    buf_q.push_back(sum[7:0]);
    buf_q.push_back(sum[15:8]);
    buf_q.push_back(fault == FaultTrailFirst ? ~cfg_sync2 : cfg_sync2);
    buf_q.push_back((fault == FaultTrailLast || fault == FaultSumTrail) ? ~cfg_sync1
                                                                         : cfg_sync1);
  endtask

  // Mostly well-formed frames with random content, some damage and noise
  task automatic random_buffer();
    int pick;
    logic [7:0] len_byte;
    frame_fault_e fault;
    pick     = $urandom_range(99);
    len_byte = cfg_exp_len;
    fault    = FaultNone;
    if (pick < 13) begin
      buf_q.delete();
      push_noise($urandom_range(1, 12));
    end else begin
      if (pick < 18) len_byte = cfg_exp_len ^ 8'($urandom_range(1, 255));
      else if (pick < 28) fault = FaultSum;
      else if (pick < 32) fault = FaultTrailFirst;
      else if (pick < 35) fault = FaultTrailLast;
      else if (pick < 37) fault = FaultSumTrail;
      build_frame($urandom_range(3), len_byte, cfg_exp_len, 16'($urandom),
                  -1, fault);
      if (pick >= 37 && pick < 50) drop_tail($urandom_range(1, 8 + cfg_exp_len));
      else if ($urandom_range(3) == 0) push_noise($urandom_range(1, 3));
    end
    send_buffer();
  endtask

  // Reset register values, before any write
  task automatic test_reset_values();
    build_frame(0, scfd_pkg::ExpLenRst, 0, 16'h1234, -1, FaultNone);
    send_buffer();
    build_frame(1, scfd_pkg::ExpLenRst, 0, 16'hBEEF, -1, FaultSum);
    send_buffer();
  endtask

  task automatic test_directed_frames();
    int hdr_cuts[4]   = '{10, 9, 8, 7};
    int trunc_cuts[5] = '{6, 4, 3, 2, 1};
    apply_settings(8'd3, 8'hAA, 8'h55);
    // payload and sequence extremes
    build_frame(0, 8'd3, 3, 16'hFFFF, 8'h00, FaultNone);
    send_buffer();
    build_frame(2, 8'd3, 3, 16'h0000, 8'hFF, FaultNone);
    send_buffer();
    // buffer ends on second sync, length, sequence low, sequence high
    foreach (hdr_cuts[i]) begin
      build_frame(5, 8'd3, 3, 16'($urandom), -1, FaultNone);
      drop_tail(hdr_cuts[i]);
      send_buffer();
    end
    // buffer ends inside payload, checksum or trailer
    foreach (trunc_cuts[i]) begin
      build_frame(2, 8'd3, 3, 16'($urandom), -1, FaultNone);
      drop_tail(trunc_cuts[i]);
      send_buffer();
    end
    // length mismatch, bad checksum, bad trailer bytes, checksum beats trailer
    build_frame(0, 8'hFF, 3, 16'h0102, -1, FaultNone);
    send_buffer();
    build_frame(0, 8'd3, 3, 16'h0304, -1, FaultSum);
    send_buffer();
    build_frame(0, 8'd3, 3, 16'h0506, -1, FaultTrailFirst);
    send_buffer();
    build_frame(0, 8'd3, 3, 16'h0708, -1, FaultTrailLast);
    send_buffer();
    build_frame(0, 8'd3, 3, 16'h090A, -1, FaultSumTrail);
    send_buffer();
    // a second sync pair after the verdict is ignored
    build_frame(0, 8'd3, 3, 16'h4321, -1, FaultNone);
    buf_q.push_back(cfg_sync1);
    buf_q.push_back(cfg_sync2);
    push_noise(4);
    send_buffer();
    // first sync byte as the last byte of the buffer
    buf_q.delete();
    repeat (6) buf_q.push_back(8'h00);
    buf_q.push_back(cfg_sync1);
    send_buffer();
    // fewer than seven bytes, sync pair present
    build_frame(0, 8'd3, 3, 16'h1111, -1, FaultNone);
    drop_tail(6);
    send_buffer();
    // one-byte buffer
    buf_q.delete();
    buf_q.push_back(cfg_sync1);
    send_buffer();
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned s_idle,
                                     input int unsigned r_stall, input logic [7:0] len,
                                     input logic [7:0] s1, input logic [7:0] s2);
    int unsigned start;
    apply_settings(len, s1, s2);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) random_buffer();
  endtask

  // Sender holds off until every predicted result has arrived, then resumes
  task automatic test_sender_pause();
    repeat (3) random_buffer();
    wait_drain();
    repeat (3) random_buffer();
  endtask

  // Longest payload, once good and once cut short inside the payload
  task automatic test_max_length();
    apply_settings(8'd255, 8'hAA, 8'h55);
    send_idle_pct  = 0;
    recv_stall_pct = 22;
    build_frame(1, 8'd255, 255, 16'hA5C3, 8'hFF, FaultNone);
    send_buffer();
    build_frame(0, 8'd255, 255, 16'h5A3C, -1, FaultNone);
    drop_tail($urandom_range(230, 255));
    send_buffer();
  endtask

  initial begin
    rst_ni               = 1'b0;
    rx_bus.valid         = 1'b0;
    rx_bus.rx_byte       = '0;
    rx_bus.end_of_buffer = 1'b0;
    res_bus.ready        = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cfg_exp_len          = scfd_pkg::ExpLenRst;
    cfg_sync1            = scfd_pkg::Sync1Rst;
    cfg_sync2            = scfd_pkg::Sync2Rst;
    good_seq             = '0;
    reset_frame_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_reset_values();
    test_directed_frames();
    test_random_traffic(25, 0, 0, 8'd4, 8'hAA, 8'h55);
    test_random_traffic(25, 79, 0, 8'd0, 8'h00, 8'hFF);
    test_random_traffic(25, 0, 79, 8'd7, 8'hFF, 8'h00);
    test_random_traffic(25, 22, 22, 8'($urandom_range(1, 6)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
    test_random_traffic(10, 22, 22, 8'd2, 8'h3C, 8'h3C);
    test_sender_pause();
    test_max_length();
    wait_drain();

    if (errors == 0) begin
      $display("sync_checksum_frame_deframer_core_tb: PASS");
    end else begin
      $display("sync_checksum_frame_deframer_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
